@@ hdl/crs_pkg.sv @@
// Shared types, constants and helpers for the Cartesian rank shift block.
// No dependencies; every other file imports this package.
package crs_pkg;

    localparam int MAX_DIMS      = 4;
    localparam int RANK_BITS     = 16;
    localparam int SIZE_BITS     = 16;
    localparam int DIR_BITS      = 2;
    localparam int DISP_BITS     = 17;
    localparam int NUM_DIMS_BITS = 3;
    localparam int CNT_BITS      = $clog2(MAX_DIMS + 1);
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Saturated weights: 2**RANK_BITS stands for any product above every rank.
    localparam int WSAT_BITS = RANK_BITS + 1;
    localparam logic [WSAT_BITS-1:0] WSAT_MAX = WSAT_BITS'(1) << RANK_BITS;

    // Divider width covers a rank and the magnitude of a displacement.
    localparam int DIV_BITS    = (RANK_BITS + 1 > DISP_BITS) ? RANK_BITS + 1 : DISP_BITS;
    localparam int DIV_STAGES  = DIV_BITS;
    // The weight products settle through a registered chain after a size write.
    localparam int PREP_STAGES = (MAX_DIMS - 1 > 3) ? MAX_DIMS - 1 : 3;
    localparam int PIPE_STAGES = PREP_STAGES + 2 * DIV_STAGES + 3;
    localparam int C_BITS      = DISP_BITS + 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_NUM_DIMS  = 3'd0,
        CFG_DIM0_SIZE = 3'd1,
        CFG_DIM1_SIZE = 3'd2,
        CFG_DIM2_SIZE = 3'd3,
        CFG_DIM3_SIZE = 3'd4,
        CFG_PERIODIC  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [MAX_DIMS-1:0][SIZE_BITS-1:0] ext;
        logic [MAX_DIMS-1:0][WSAT_BITS-1:0] wsat;
        logic [MAX_DIMS-1:0][RANK_BITS-1:0] wmod;
        logic [WSAT_BITS-1:0]               wcnt;
        logic [CNT_BITS-1:0]                count;
        logic [MAX_DIMS-1:0]                per;
    } t_geom;

    typedef struct packed {
        logic                  in_ready;
        logic [PIPE_STAGES-1:0] en;
        logic [PIPE_STAGES-1:0] vld;
    } t_pipe;

    typedef struct packed {
        logic [RANK_BITS-1:0]        rank;
        logic [DIR_BITS-1:0]         dir;
        logic signed [DISP_BITS-1:0] disp;
        logic [DISP_BITS-1:0]        absd;
        logic                        bad;
        logic                        per;
        logic [SIZE_BITS-1:0]        e;
    } t_pre;

    typedef struct packed {
        logic                        bad;
        logic                        per;
        logic                        neg;
        logic [SIZE_BITS-1:0]        e;
        logic [RANK_BITS-1:0]        wmod;
        logic signed [DISP_BITS-1:0] disp;
        logic [SIZE_BITS-1:0]        m;
        logic [RANK_BITS-1:0]        top;
    } t_side;

    typedef struct packed {
        logic                 bad;
        logic                 nn;
        logic [RANK_BITS-1:0] top;
        logic [RANK_BITS-1:0] wmod;
        logic [SIZE_BITS-1:0] oldc;
        logic [SIZE_BITS-1:0] newc;
    } t_fin0;

    typedef struct packed {
        logic                 bad;
        logic                 nn;
        logic [RANK_BITS-1:0] top;
        logic [RANK_BITS-1:0] prod;
    } t_fin1;

    function automatic logic [WSAT_BITS-1:0] sat_mul(input logic [WSAT_BITS-1:0] w,
                                                    input logic [SIZE_BITS-1:0] e);
        logic [WSAT_BITS+SIZE_BITS-1:0] p;
        p = w * e;
        return (p > (WSAT_BITS+SIZE_BITS)'(WSAT_MAX)) ? WSAT_MAX : p[WSAT_BITS-1:0];
    endfunction

endpackage

@@ hdl/crs_if.sv @@
// Valid/ready channel interfaces for items in and results out.
// Depends on crs_pkg for the field widths.
interface crs_in_if import crs_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic [RANK_BITS-1:0]        from_rank;
    logic [DIR_BITS-1:0]         direction;
    logic signed [DISP_BITS-1:0] displacement;

    modport source(output valid, from_rank, direction, displacement, input ready);
    modport sink(input valid, from_rank, direction, displacement, output ready);
endinterface

interface crs_out_if import crs_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [RANK_BITS-1:0] neighbour_rank;
    logic                 no_neighbour;
    logic                 status;

    modport source(output valid, neighbour_rank, no_neighbour, status, input ready);
    modport sink(input valid, neighbour_rank, no_neighbour, status, output ready);
endinterface

@@ hdl/crs_cfg.sv @@
// Configuration registers and the registered chain of dimension weights.
// Depends on crs_pkg.
module crs_cfg import crs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_geom                    o_geom
);

    logic [NUM_DIMS_BITS-1:0] r_num;
    logic [SIZE_BITS-1:0]     r_size [MAX_DIMS];
    logic [MAX_DIMS-1:0]      r_per;
    logic [WSAT_BITS-1:0]     r_wsat [MAX_DIMS-1];
    logic [RANK_BITS-1:0]     r_wlo  [MAX_DIMS-2];

    logic [SIZE_BITS-1:0] ext   [MAX_DIMS];
    logic [WSAT_BITS-1:0] w_sat [MAX_DIMS+1];
    logic [RANK_BITS-1:0] w_lo  [MAX_DIMS];
    logic [CNT_BITS-1:0]  count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= NUM_DIMS_BITS'(1);
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_size[d] <= SIZE_BITS'(1);
            end
            r_per <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NUM_DIMS:  r_num     <= i_cfg_data[NUM_DIMS_BITS-1:0];
                CFG_DIM0_SIZE: r_size[0] <= i_cfg_data[SIZE_BITS-1:0];
                CFG_DIM1_SIZE: r_size[1] <= i_cfg_data[SIZE_BITS-1:0];
                CFG_DIM2_SIZE: r_size[2] <= i_cfg_data[SIZE_BITS-1:0];
                CFG_DIM3_SIZE: r_size[3] <= i_cfg_data[SIZE_BITS-1:0];
                CFG_PERIODIC:  r_per     <= i_cfg_data[MAX_DIMS-1:0];
                default: ;
            endcase
        end
    end

    // One multiply per register: from weight 2 up, weight d+1 follows from weight d in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < MAX_DIMS - 1; d++) begin
                r_wsat[d] <= WSAT_BITS'(1);
            end
            for (int d = 0; d < MAX_DIMS - 2; d++) begin
                r_wlo[d] <= RANK_BITS'(1);
            end
        end else begin
            for (int d = 0; d < MAX_DIMS - 1; d++) begin
                r_wsat[d] <= sat_mul(w_sat[d+1], ext[d+1]);
            end
            for (int d = 0; d < MAX_DIMS - 2; d++) begin
                r_wlo[d] <= RANK_BITS'(w_lo[d+1] * ext[d+1]);
            end
        end
    end

    always_comb begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            ext[d] = (r_size[d] == '0) ? SIZE_BITS'(1) : r_size[d];
        end
        w_sat[0] = WSAT_BITS'(1);
        w_sat[1] = WSAT_BITS'(ext[0]);
        for (int d = 2; d <= MAX_DIMS; d++) begin
            w_sat[d] = r_wsat[d-2];
        end
        w_lo[0] = RANK_BITS'(1);
        w_lo[1] = RANK_BITS'(ext[0]);
        for (int d = 2; d < MAX_DIMS; d++) begin
            w_lo[d] = r_wlo[d-2];
        end
        count = (r_num > NUM_DIMS_BITS'(MAX_DIMS)) ? CNT_BITS'(MAX_DIMS) : CNT_BITS'(r_num);

        for (int d = 0; d < MAX_DIMS; d++) begin
            o_geom.ext[d]  = ext[d];
            o_geom.wsat[d] = w_sat[d];
            o_geom.wmod[d] = w_lo[d];
        end
        o_geom.wcnt  = w_sat[count];
        o_geom.count = count;
        o_geom.per   = r_per;
    end

endmodule

@@ hdl/crs_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on crs_pkg; stage enables come from the pipeline control.
module crs_div import crs_pkg::*; (
    input  logic                  i_clk,
    input  logic [DIV_STAGES-1:0] i_en,
    input  logic [DIV_BITS-1:0]   i_dividend,
    input  logic [DIV_BITS-1:0]   i_divisor,
    output logic [DIV_BITS-1:0]   o_quotient,
    output logic [DIV_BITS-1:0]   o_remainder
);

    logic [DIV_BITS-1:0] r_rem [DIV_STAGES];
    logic [DIV_BITS-1:0] r_acc [DIV_STAGES];
    logic [DIV_BITS-1:0] r_dvs [DIV_STAGES];
    logic [DIV_BITS-1:0] n_rem [DIV_STAGES];
    logic [DIV_BITS-1:0] n_acc [DIV_STAGES];
    logic [DIV_BITS-1:0] n_dvs [DIV_STAGES];

    always_comb begin
        logic [DIV_BITS:0]   t;
        logic [DIV_BITS-1:0] prem, pacc, pdvs;
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                prem = '0;
                pacc = i_dividend;
                pdvs = i_divisor;
            end else begin
                prem = r_rem[s-1];
                pacc = r_acc[s-1];
                pdvs = r_dvs[s-1];
            end
            // The accumulator shifts dividend bits out and quotient bits in.
            t = {prem, pacc[DIV_BITS-1]};
            if (t >= {1'b0, pdvs}) begin
                t = t - {1'b0, pdvs};
                n_acc[s] = {pacc[DIV_BITS-2:0], 1'b1};
            end else begin
                n_acc[s] = {pacc[DIV_BITS-2:0], 1'b0};
            end
            n_rem[s] = t[DIV_BITS-1:0];
            n_dvs[s] = pdvs;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (i_en[s]) begin
                r_rem[s] <= n_rem[s];
                r_acc[s] <= n_acc[s];
                r_dvs[s] <= n_dvs[s];
            end
        end
    end

    assign o_quotient  = r_acc[DIV_STAGES-1];
    assign o_remainder = r_rem[DIV_STAGES-1];

endmodule

@@ hdl/crs_ctrl.sv @@
// Valid bits and per-stage load enables of the item pipeline.
// Depends on crs_pkg; a bubble anywhere downstream lets the stages above it move.
module crs_ctrl import crs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_ready,
    output t_pipe o_pipe
);

    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] n_vld;
    logic [PIPE_STAGES-1:0] en;

    always_comb begin
        for (int k = 0; k < PIPE_STAGES; k++) begin
            // A stage may load when the output is ready or when it or any stage after it is empty.
            en[k] = i_out_ready || (((~r_vld) >> k) != '0);
        end
        for (int k = 0; k < PIPE_STAGES; k++) begin
            if (en[k]) begin
                n_vld[k] = (k == 0) ? i_in_valid : r_vld[(k == 0) ? 0 : k - 1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
        o_pipe.en       = en;
        o_pipe.vld      = r_vld;
        o_pipe.in_ready = en[0] && i_rst_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

endmodule

@@ hdl/cartesian_rank_shift_top.sv @@
// Cartesian grid neighbour lookup: rank, direction and displacement in,
// neighbour rank, off-grid flag and status out.
// Uses crs_pkg, crs_if, crs_cfg, crs_ctrl and crs_div.
//
// Items enter on i_in and results leave on o_out, both valid/ready; an item
// moves when valid and ready are high at a rising edge. Configuration is
// written through i_cfg_we/i_cfg_idx/i_cfg_data while no item is in flight.
// The block takes one item per cycle while i_in.ready is high. Each result
// passes 40 register stages, the first of which loads at the edge that
// accepts its item. The stages are two chained banks of 17-stage restoring
// dividers, the first splitting the rank by the dimension weights and the
// second extracting the coordinate, plus three input and three output
// stages. The weight products settle through a registered chain after a
// size write, a chain no longer than the three input stages.
// Reset clears all valid bits and returns the registers to one dimension of
// extent one, not periodic. When the receiver stalls, results collect in
// the pipeline; empty stages still fill, and i_in.ready drops only in reset
// or when every stage holds an item.
module cartesian_rank_shift_top import crs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    crs_in_if.sink                   i_in,
    crs_out_if.source                o_out,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int B1 = PREP_STAGES;
    localparam int B2 = B1 + DIV_STAGES;
    localparam int F0 = B2 + DIV_STAGES;
    localparam int F1 = F0 + 1;
    localparam int F2 = F1 + 1;

    t_geom geom;
    t_pipe pipe;

    t_pre  r_pre [PREP_STAGES];
    t_side r_s1  [DIV_STAGES];
    t_side r_s2  [DIV_STAGES];
    t_fin0 r_f0;
    t_fin1 r_f1;
    logic [RANK_BITS-1:0] r_rank;
    logic                 r_nn;
    logic                 r_st;

    t_pre  n_pre;
    t_side n_s1;
    t_side n_s2;
    t_fin0 n_f0;
    t_fin1 n_f1;

    logic [DIV_BITS-1:0] a_quo;
    logic [DIV_BITS-1:0] b_rem;
    logic [DIV_BITS-1:0] c_rem;
    logic [DIV_BITS-1:0] d_rem;

    crs_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_geom     (geom)
    );

    crs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_pipe      (pipe)
    );

    assign i_in.ready = pipe.in_ready;

    // Input decode.
    always_comb begin
        n_pre.rank = i_in.from_rank;
        n_pre.dir  = i_in.direction;
        n_pre.disp = i_in.displacement;
        n_pre.absd = i_in.displacement[DISP_BITS-1] ? DISP_BITS'(-i_in.displacement)
                                                    : DISP_BITS'(i_in.displacement);
        n_pre.bad  = CNT_BITS'(i_in.direction) >= geom.count;
        n_pre.per  = geom.per[i_in.direction];
        n_pre.e    = geom.ext[i_in.direction];
    end

    always_ff @(posedge i_clk) begin
        if (pipe.en[0]) begin
            r_pre[0] <= n_pre;
        end
        for (int s = 1; s < PREP_STAGES; s++) begin
            if (pipe.en[s]) begin
                r_pre[s] <= r_pre[s-1];
            end
        end
    end

    // First bank: rank over the direction weight, rank modulo the grid
    // volume and the displacement magnitude modulo the extent, side by side.
    crs_div u_div_a (
        .i_clk       (i_clk),
        .i_en        (pipe.en[B1 +: DIV_STAGES]),
        .i_dividend  (DIV_BITS'(r_pre[PREP_STAGES-1].rank)),
        .i_divisor   (DIV_BITS'(geom.wsat[r_pre[PREP_STAGES-1].dir])),
        .o_quotient  (a_quo),
        .o_remainder ()
    );

    crs_div u_div_c (
        .i_clk       (i_clk),
        .i_en        (pipe.en[B1 +: DIV_STAGES]),
        .i_dividend  (DIV_BITS'(r_pre[PREP_STAGES-1].rank)),
        .i_divisor   (DIV_BITS'(geom.wcnt)),
        .o_quotient  (),
        .o_remainder (c_rem)
    );

    crs_div u_div_d (
        .i_clk       (i_clk),
        .i_en        (pipe.en[B1 +: DIV_STAGES]),
        .i_dividend  (DIV_BITS'(r_pre[PREP_STAGES-1].absd)),
        .i_divisor   (DIV_BITS'(r_pre[PREP_STAGES-1].e)),
        .o_quotient  (),
        .o_remainder (d_rem)
    );

    always_comb begin
        n_s1.bad  = r_pre[PREP_STAGES-1].bad;
        n_s1.per  = r_pre[PREP_STAGES-1].per;
        n_s1.neg  = r_pre[PREP_STAGES-1].disp[DISP_BITS-1];
        n_s1.e    = r_pre[PREP_STAGES-1].e;
        n_s1.wmod = geom.wmod[r_pre[PREP_STAGES-1].dir];
        n_s1.disp = r_pre[PREP_STAGES-1].disp;
        n_s1.m    = '0;
        n_s1.top  = '0;
    end

    // True modulo of the displacement: a negative shift with a nonzero
    // remainder lands on the extent minus that remainder.
    always_comb begin
        logic [SIZE_BITS-1:0] rd;
        rd   = d_rem[SIZE_BITS-1:0];
        n_s2 = r_s1[DIV_STAGES-1];
        n_s2.m   = (r_s1[DIV_STAGES-1].neg && rd != '0) ? r_s1[DIV_STAGES-1].e - rd : rd;
        n_s2.top = c_rem[RANK_BITS-1:0];
    end

    // Second bank: the coordinate along the direction.
    crs_div u_div_b (
        .i_clk       (i_clk),
        .i_en        (pipe.en[B2 +: DIV_STAGES]),
        .i_dividend  (a_quo),
        .i_divisor   (DIV_BITS'(r_s1[DIV_STAGES-1].e)),
        .o_quotient  (),
        .o_remainder (b_rem)
    );

    always_ff @(posedge i_clk) begin
        if (pipe.en[B1]) begin
            r_s1[0] <= n_s1;
        end
        if (pipe.en[B2]) begin
            r_s2[0] <= n_s2;
        end
        for (int s = 1; s < DIV_STAGES; s++) begin
            if (pipe.en[B1 + s]) begin
                r_s1[s] <= r_s1[s-1];
            end
            if (pipe.en[B2 + s]) begin
                r_s2[s] <= r_s2[s-1];
            end
        end
    end

    // New coordinate and the off-grid check.
    always_comb begin
        logic [SIZE_BITS-1:0]     oldc;
        logic signed [C_BITS-1:0] c;
        logic signed [C_BITS-1:0] e_s;
        logic [SIZE_BITS:0]       cp;
        logic [SIZE_BITS:0]       cpw;
        t_side                    s;
        s    = r_s2[DIV_STAGES-1];
        oldc = b_rem[SIZE_BITS-1:0];
        e_s  = $signed({{(C_BITS - SIZE_BITS){1'b0}}, s.e});
        c    = $signed({{(C_BITS - SIZE_BITS){1'b0}}, oldc}) + C_BITS'(s.disp);
        cp   = {1'b0, oldc} + {1'b0, s.m};
        cpw  = (cp >= {1'b0, s.e}) ? cp - {1'b0, s.e} : cp;
        n_f0.bad  = s.bad;
        n_f0.nn   = !s.per && (c < 0 || c >= e_s);
        n_f0.top  = s.top;
        n_f0.wmod = s.wmod;
        n_f0.oldc = oldc;
        n_f0.newc = s.per ? cpw[SIZE_BITS-1:0] : c[SIZE_BITS-1:0];
    end

    // The rank moves by the coordinate change times the direction weight.
    always_comb begin
        logic [RANK_BITS-1:0]   dl;
        logic [2*RANK_BITS-1:0] pf;
        dl = RANK_BITS'(r_f0.newc - r_f0.oldc);
        pf = dl * r_f0.wmod;
        n_f1.bad  = r_f0.bad;
        n_f1.nn   = r_f0.nn;
        n_f1.top  = r_f0.top;
        n_f1.prod = pf[RANK_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (pipe.en[F0]) begin
            r_f0 <= n_f0;
        end
        if (pipe.en[F1]) begin
            r_f1 <= n_f1;
        end
        if (pipe.en[F2]) begin
            r_rank <= (r_f1.bad || r_f1.nn) ? '0 : r_f1.top + r_f1.prod;
            r_nn   <= !r_f1.bad && r_f1.nn;
            r_st   <= r_f1.bad;
        end
    end

    assign o_out.valid          = pipe.vld[PIPE_STAGES-1];
    assign o_out.neighbour_rank = r_rank;
    assign o_out.no_neighbour   = r_nn;
    assign o_out.status         = r_st;

endmodule

@@ hdl/crs_checker.sv @@
// Port-level checks for the Cartesian rank shift block, bound to the top.
// Depends on crs_pkg and cartesian_rank_shift_top.
module crs_checker import crs_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [RANK_BITS-1:0] i_rank,
    input logic                 i_nn,
    input logic                 i_status
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_rank) && $stable(i_nn) && $stable(i_status)))
        else $error("stalled result changed");

    a_bad_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status) |-> (i_rank == '0 && !i_nn))
        else $error("bad direction result not cleared");

    a_off_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_nn) |-> (i_rank == '0 && !i_status))
        else $error("off-grid result not cleared");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output drains");

endmodule

bind cartesian_rank_shift_top crs_checker u_crs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_rank      (o_out.neighbour_rank),
    .i_nn        (o_out.no_neighbour),
    .i_status    (o_out.status)
);

@@ sim/tb_cartesian_rank_shift_top.sv @@
// Testbench for the Cartesian rank shift block: drives neighbour lookups over
// several grid settings and checks each result against an in-bench predictor.
// Depends on crs_pkg, crs_if and cartesian_rank_shift_top.
module tb_cartesian_rank_shift_top;
    import crs_pkg::*;

    typedef struct packed {
        logic [RANK_BITS-1:0]        rank;
        logic [DIR_BITS-1:0]         dir;
        logic signed [DISP_BITS-1:0] disp;
    } t_lookup;

    typedef struct packed {
        logic [RANK_BITS-1:0] rank;
        logic                 off_grid;
        logic                 bad_dir;
    } t_neighbour;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    crs_in_if  in_ch();
    crs_out_if out_ch();

    cartesian_rank_shift_top u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch.sink),
        .o_out     (out_ch.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // Predictor copy of the configuration.
    logic [NUM_DIMS_BITS-1:0] grid_dims;
    logic [SIZE_BITS-1:0]     grid_size [MAX_DIMS];
    logic [MAX_DIMS-1:0]      grid_wrap;

    t_lookup    lookup_q[$];
    t_neighbour neighbour_q[$];

    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req = 1'b0;
    bit hold_ack;
    int hold_recv;
    int mismatches = 0;
    int quiet_cycles = 0;
    bit timed_out = 1'b0;

    localparam int WATCHDOG    = 20000;
    localparam int HOLD_CYCLES = 300;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_neighbour predict_neighbour(t_lookup lk);
        t_neighbour res;
        longint     coord [MAX_DIMS];
        longint     ext, rest, c, acc, weight;
        int         cnt;
        res  = '0;
        cnt  = (grid_dims > MAX_DIMS) ? MAX_DIMS : int'(grid_dims);
        rest = lk.rank;
        if (lk.dir >= cnt) begin
            res.bad_dir = 1'b1;
            return res;
        end
        for (int i = 0; i < cnt; i++) begin
            ext = (grid_size[i] == 0) ? 1 : grid_size[i];
            coord[i] = rest % ext;
            rest = rest / ext;
        end
        ext = (grid_size[lk.dir] == 0) ? 1 : grid_size[lk.dir];
        c = coord[lk.dir] + longint'(lk.disp);
        if (grid_wrap[lk.dir]) begin
            c = c % ext;
            if (c < 0) c += ext;
        end else if (c < 0 || c >= ext) begin
            res.off_grid = 1'b1;
            return res;
        end
        coord[lk.dir] = c;
        acc = 0;
        weight = 1;
        for (int i = 0; i < cnt; i++) begin
            acc += coord[i] * weight;
            weight *= (grid_size[i] == 0) ? 1 : grid_size[i];
        end
        res.rank = acc[RANK_BITS-1:0];
        return res;
    endfunction

    // Driver: takes lookups from the queue and offers them with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid        <= 1'b0;
            in_ch.from_rank    <= '0;
            in_ch.direction    <= '0;
            in_ch.displacement <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                t_lookup done_lk;
                done_lk = lookup_q.pop_front();
                neighbour_q = {neighbour_q, predict_neighbour(done_lk)};
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (lookup_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_lookup nx;
                    nx = lookup_q[0];
                    in_ch.valid        <= 1'b1;
                    in_ch.from_rank    <= nx.rank;
                    in_ch.direction    <= nx.dir;
                    in_ch.displacement <= nx.disp;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_ack     <= 1'b0;
            hold_recv    <= 0;
        end else if (hold_req != hold_ack) begin
            hold_ack     <= hold_req;
            hold_recv    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_recv > 0) begin
            hold_recv <= hold_recv - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (neighbour_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result: rank %0d off %0b bad %0b",
                                 out_ch.neighbour_rank, out_ch.no_neighbour, out_ch.status);
                end else begin
                    t_neighbour ex;
                    ex = neighbour_q.pop_front();
                    if (ex.rank !== out_ch.neighbour_rank || ex.off_grid !== out_ch.no_neighbour
                            || ex.bad_dir !== out_ch.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected rank %0d off %0b bad %0b, got %0d %0b %0b",
                                     ex.rank, ex.off_grid, ex.bad_dir, out_ch.neighbour_rank,
                                     out_ch.no_neighbour, out_ch.status);
                    end
                end
            end
            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)
                    || (lookup_q.size() == 0 && neighbour_q.size() == 0))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) timed_out = 1'b1;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_NUM_DIMS:  grid_dims = val[NUM_DIMS_BITS-1:0];
            CFG_DIM0_SIZE: grid_size[0] = val;
            CFG_DIM1_SIZE: grid_size[1] = val;
            CFG_DIM2_SIZE: grid_size[2] = val;
            CFG_DIM3_SIZE: grid_size[3] = val;
            CFG_PERIODIC:  grid_wrap = val[MAX_DIMS-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_grid(input int dims, input int s0, input int s1, input int s2,
                            input int s3, input int wrap);
        write_reg(CFG_NUM_DIMS, CFG_DATA_BITS'(dims));
        write_reg(CFG_DIM0_SIZE, CFG_DATA_BITS'(s0));
        write_reg(CFG_DIM1_SIZE, CFG_DATA_BITS'(s1));
        write_reg(CFG_DIM2_SIZE, CFG_DATA_BITS'(s2));
        write_reg(CFG_DIM3_SIZE, CFG_DATA_BITS'(s3));
        write_reg(CFG_PERIODIC, CFG_DATA_BITS'(wrap));
        repeat (8) @(posedge i_clk);
    endtask

    task automatic drain();
        while ((lookup_q.size() != 0 || neighbour_q.size() != 0) && !timed_out)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic t_lookup random_lookup();
        t_lookup lk;
        longint  span;
        int      dmax;
        span = 1;
        for (int i = 0; i < MAX_DIMS; i++)
            if (i < grid_dims) span *= (grid_size[i] == 0) ? 1 : grid_size[i];
        dmax = (grid_dims == 0) ? 1 : ((grid_dims > 4) ? 4 : int'(grid_dims));
        lk.rank = RANK_BITS'(($urandom_range(9) == 0 || span > 65535) ? $urandom
                                 : $urandom_range(32'(span - 1)));
        lk.dir  = DIR_BITS'(($urandom_range(7) == 0) ? $urandom
                                : $urandom_range(32'(dmax - 1)));
        case ($urandom_range(3))
            0: lk.disp = $signed(17'($urandom_range(6))) - 17'sd3;
            1: lk.disp = $signed(17'($urandom_range(40))) - 17'sd20;
            2: lk.disp = DISP_BITS'($urandom);
            default: lk.disp = $urandom_range(1) ? 17'sh10001 : 17'shFFFF;
        endcase
        return lk;
    endfunction

    task automatic run_random(input int n, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++) lookup_q = {lookup_q, random_lookup()};
        drain();
    endtask

    initial begin
        t_lookup lk;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        grid_dims = 1;
        for (int i = 0; i < MAX_DIMS; i++) grid_size[i] = 1;
        grid_wrap = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset grid, extremes of fields, wraps, off-grid, bad dirs.
        lk = '{16'hFFFF, 2'd0, 17'sh0FFFF}; lookup_q = {lookup_q, lk};
        lk = '{16'h0000, 2'd3, 17'sh10001}; lookup_q = {lookup_q, lk};
        drain();
        set_grid(4, 3, 4, 5, 2, 4'b0101);
        lk = '{16'd0, 2'd0, -17'sd1};          lookup_q = {lookup_q, lk};
        lk = '{16'd0, 2'd0, -17'sd65535};      lookup_q = {lookup_q, lk};
        lk = '{16'd119, 2'd2, 17'sd65535};     lookup_q = {lookup_q, lk};
        lk = '{16'd119, 2'd1, 17'sd1};         lookup_q = {lookup_q, lk};
        lk = '{16'd5, 2'd1, -17'sd2};          lookup_q = {lookup_q, lk};
        lk = '{16'd65535, 2'd3, 17'sd1};       lookup_q = {lookup_q, lk};
        lk = '{16'd42, 2'd3, -17'sd1};         lookup_q = {lookup_q, lk};
        lk = '{16'hAAAA, 2'd2, 17'sh0AAAA};    lookup_q = {lookup_q, lk};
        lk = '{16'h5555, 2'd0, 17'sh15555};    lookup_q = {lookup_q, lk};
        drain();
        set_grid(0, 0, 7, 7, 7, 4'hF);
        lk = '{16'd3, 2'd0, 17'sd1}; lookup_q = {lookup_q, lk};
        drain();
        set_grid(7, 0, 65535, 2, 3, 4'b1010);
        lk = '{16'hFFFF, 2'd1, 17'sd1}; lookup_q = {lookup_q, lk};
        lk = '{16'd1, 2'd0, 17'sd0};    lookup_q = {lookup_q, lk};
        drain();

        // Random phases over several grids and idling mixes.
        set_grid(2, 16, 16, 1, 1, 4'b0001);
        run_random(300, 0, 0);
        set_grid(3, 7, 5, 9, 1, 4'b0110);
        run_random(300, 77, 0);
        set_grid(4, 4, 3, 5, 6, 4'b1001);
        run_random(300, 0, 77);
        set_grid(4, 65535, 65535, 65535, 65535, 4'b1111);
        run_random(200, 24, 24);
        set_grid(1, 65535, 1, 1, 1, 4'b0000);
        run_random(200, 24, 24);

        // Long receiver hold-off while the sender keeps offering items.
        set_grid(3, 10, 10, 10, 1, 4'b0011);
        hold_req = ~hold_req;
        run_random(300, 0, 0);
        // The drain above is the sender pausing until every result has come.
        run_random(100, 24, 24);

        if (!timed_out && mismatches == 0 && neighbour_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        wait (timed_out);
        $display("FAILURE");
        $finish;
    end
endmodule
